// ===== rtl/fwm_pkg.sv =====
// fwm_pkg: shared constants, types and the alpha lookup table for the frame rate window meter
// no dependencies

package fwm_pkg;

  localparam int QUEUE_DEPTH         = 256;
  localparam int ALPHA_TABLE_ENTRIES = 256;

  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int AIDX_W  = $clog2(ALPHA_TABLE_ENTRIES);
  localparam int DIV_W   = 48;
  localparam int DCNT_W  = $clog2(DIV_W + 1);

  localparam logic [23:0] WIN_RESET = 24'd1000000;
  localparam logic [DIV_W-1:0] US_PER_S = DIV_W'(1000000);
  localparam logic [DIV_W-1:0] ATE_MUL  = DIV_W'(ALPHA_TABLE_ENTRIES);

  // event kinds
  localparam logic [1:0] K_FRAME  = 2'd0;
  localparam logic [1:0] K_PAUSE  = 2'd1;
  localparam logic [1:0] K_RESUME = 2'd2;
  localparam logic [1:0] K_START  = 2'd3;

  typedef logic [15:0] alpha_tab_t [ALPHA_TABLE_ENTRIES];

  typedef struct packed {
    logic in_take;
    logic evt;
    logic full_drop;
    logic push;
    logic chk_drop;
    logic div_start;
    logic div_sel_idx;
    logic rate_cap;
    logic alpha_cap;
    logic mul;
    logic upd;
    logic out_load;
  } fwm_cmd_t;

  typedef struct packed {
    logic frame_go;
    logic full;
    logic drop_ok;
    logic total_zero;
    logic div_done;
    logic out_busy;
  } fwm_stat_t;

  // 1 - exp(-8*i/N) in Q0.16, exp as (4th order taylor of exp(-x/256))^256 in Q1.31
  function automatic alpha_tab_t alpha_table();
    alpha_tab_t t;
    logic [63:0] y, y2, y3, y4, e, a;
    for (int i = 0; i < ALPHA_TABLE_ENTRIES; i++) begin
      y  = (64'(i) << 26) / 64'(ALPHA_TABLE_ENTRIES);
      y2 = (y * y) >> 31;
      y3 = (y2 * y) >> 31;
      y4 = (y3 * y) >> 31;
      e  = (64'h8000_0000 - y + y2 / 64'd2 + y4 / 64'd24) - y3 / 64'd6;
      for (int k = 0; k < 8; k++) begin
        e = (e * e + 64'h4000_0000) >> 31;
      end
      if (e > 64'h8000_0000) e = 64'h8000_0000;
      a = ((64'h8000_0000 - e) + 64'h4000) >> 15;
      t[i] = (a > 64'hFFFF) ? 16'hFFFF : a[15:0];
    end
    return t;
  endfunction

  localparam alpha_tab_t ALPHA_TAB = alpha_table();

endpackage

// ===== rtl/fwm_div.sv =====
// fwm_div: restoring divider, one quotient bit per cycle
// depends on fwm_pkg

module fwm_div import fwm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  output logic [DIV_W-1:0] quo,
  output logic             done
);

  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DIV_W-1:0]  den_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r, done_r;
  logic [DIV_W:0]    trial;
  logic              qbit;

  always_comb begin
    trial   = {rem_r, quo_r[DIV_W-1]};
    qbit    = (trial >= {1'b0, den_r});
    rem_nxt = qbit ? DIV_W'(trial - {1'b0, den_r}) : trial[DIV_W-1:0];
    quo_nxt = {quo_r[DIV_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

// ===== rtl/fwm_ctrl.sv =====
// fwm_ctrl: sequencer for one event, drives datapath commands
// depends on fwm_pkg

module fwm_ctrl import fwm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  fwm_stat_t st,
  output fwm_cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_EVT       = 11'b000_0000_0010,
    S_FULL_DROP = 11'b000_0000_0100,
    S_PUSH      = 11'b000_0000_1000,
    S_CHK_RD    = 11'b000_0001_0000,
    S_CHK       = 11'b000_0010_0000,
    S_DIV_RATE  = 11'b000_0100_0000,
    S_DIV_IDX   = 11'b000_1000_0000,
    S_MUL       = 11'b001_0000_0000,
    S_UPD       = 11'b010_0000_0000,
    S_DONE      = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.in_take = 1'b1;
          state_nxt   = S_EVT;
        end
      end
      S_EVT: begin
        cmd.evt = 1'b1;
        if (st.frame_go) state_nxt = st.full ? S_FULL_DROP : S_PUSH;
        else             state_nxt = S_IDLE;
      end
      S_FULL_DROP: begin
        cmd.full_drop = 1'b1;
        state_nxt     = S_PUSH;
      end
      S_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = S_CHK_RD;
      end
      S_CHK_RD: state_nxt = S_CHK;
      S_CHK: begin
        if (st.drop_ok) begin
          cmd.chk_drop = 1'b1;
          state_nxt    = S_CHK_RD;
        end else if (st.total_zero) begin
          state_nxt = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV_RATE;
        end
      end
      S_DIV_RATE: begin
        if (st.div_done) begin
          cmd.rate_cap    = 1'b1;
          cmd.div_start   = 1'b1;
          cmd.div_sel_idx = 1'b1;
          state_nxt       = S_DIV_IDX;
        end
      end
      S_DIV_IDX: begin
        if (st.div_done) begin
          cmd.alpha_cap = 1'b1;
          state_nxt     = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ===== rtl/fwm_dp.sv =====
// fwm_dp: datapath with time base, interval queue memory, divider, smoothing and output register
// depends on fwm_pkg and fwm_div

module fwm_dp import fwm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  fwm_cmd_t    cmd,
  output fwm_stat_t   st,
  input  logic        cfg_valid,
  input  logic [23:0] cfg_sample_window_us,
  input  logic [1:0]  in_kind,
  input  logic [47:0] in_timestamp_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_interval_us,
  output logic [31:0] out_window_rate,
  output logic [31:0] out_smoothed_rate,
  output logic [8:0]  out_frames_in_window,
  output logic        out_rate_valid
);

  logic [23:0]        win_r;
  logic [1:0]         kind_r;
  logic [47:0]        ts_r;
  logic               paused_r;
  logic [47:0]        last_r, pstart_r;
  logic [39:0]        total_r;
  logic [PTR_W-1:0]   head_r;
  logic [COUNT_W-1:0] count_r;
  logic [31:0]        diff_r, rate_r, avg_r;
  logic               avg_valid_r;
  logic [16:0]        alpha_r;
  logic [48:0]        prod_r;
  logic               up_r;
  logic [31:0]        rd_data_r;
  logic [31:0]        mem [QUEUE_DEPTH];

  logic               out_valid_r;
  logic [31:0]        o_int_r, o_rate_r, o_smooth_r;
  logic [8:0]         o_frames_r;
  logic               o_rv_r;

  logic [23:0]        win;
  logic [47:0]        d;
  logic [31:0]        diff_sat;
  logic [PTR_W:0]     tail_sum;
  logic [PTR_W-1:0]   tail, head_inc;
  logic [23:0]        m;
  logic [DIV_W-1:0]   div_num, div_den, quo;
  logic               div_done;
  logic [31:0]        absd;
  logic [48:0]        step_w;
  logic [31:0]        step;
  logic [39:0]        total_less;

  assign win      = (win_r == 24'd0) ? 24'd1 : win_r;
  assign d        = ts_r - last_r;
  assign diff_sat = d[47] ? 32'd0 : ((d[46:32] != '0) ? 32'hFFFF_FFFF : d[31:0]);
  assign tail_sum = {1'b0, head_r} + (PTR_W+1)'(count_r);
  assign tail     = (tail_sum >= (PTR_W+1)'(QUEUE_DEPTH)) ?
                    PTR_W'(tail_sum - (PTR_W+1)'(QUEUE_DEPTH)) : tail_sum[PTR_W-1:0];
  assign head_inc = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign m        = (total_r < 40'(win)) ? total_r[23:0] : win;
  assign total_less = total_r - 40'(rd_data_r);

  assign div_num = cmd.div_sel_idx ? (DIV_W'(diff_r) * ATE_MUL + DIV_W'(m))
                                   : ((DIV_W'(count_r) * US_PER_S) << 16);
  assign div_den = cmd.div_sel_idx ? (DIV_W'(m) << 1) : DIV_W'(total_r);

  assign absd   = up_r ? (rate_r - avg_r) : (avg_r - rate_r);
  assign step_w = prod_r + 49'd32768;
  assign step   = step_w[47:16];

  fwm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (quo),
    .done  (div_done)
  );

  always_comb begin
    st.frame_go   = (kind_r == K_FRAME) && !paused_r;
    st.full       = (count_r >= COUNT_W'(QUEUE_DEPTH));
    st.drop_ok    = (count_r > COUNT_W'(1)) && (total_r >= 40'(rd_data_r)) &&
                    (total_less >= 40'(win));
    st.total_zero = (total_r == 40'd0);
    st.div_done   = div_done;
    st.out_busy   = out_valid_r && !out_ready;
  end

  // queue memory, read port follows the head pointer
  always_ff @(posedge clk) begin
    if (cmd.push) mem[tail] <= diff_r;
    rd_data_r <= mem[head_r];
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= WIN_RESET;
      paused_r    <= 1'b0;
      last_r      <= '0;
      pstart_r    <= '0;
      total_r     <= '0;
      head_r      <= '0;
      count_r     <= '0;
      avg_r       <= '0;
      avg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) win_r <= cfg_sample_window_us;
      if (cmd.evt) begin
        case (kind_r)
          K_START: last_r <= ts_r;
          K_PAUSE: begin
            paused_r <= 1'b1;
            pstart_r <= ts_r;
          end
          K_RESUME: begin
            if (paused_r) begin
              last_r   <= last_r + ts_r - pstart_r;
              paused_r <= 1'b0;
            end
          end
          K_FRAME: if (!paused_r) last_r <= ts_r;
          default: ;
        endcase
      end
      if (cmd.full_drop || cmd.chk_drop) begin
        total_r <= total_less;
        head_r  <= head_inc;
        count_r <= count_r - 1'b1;
      end
      if (cmd.push) begin
        total_r <= total_r + 40'(diff_r);
        count_r <= count_r + 1'b1;
      end
      if (cmd.upd) begin
        avg_valid_r <= 1'b1;
        if (!avg_valid_r) avg_r <= rate_r;
        else if (up_r)    avg_r <= avg_r + step;
        else              avg_r <= avg_r - step;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
        if (total_r == 40'd0) begin
          avg_r       <= '0;
          avg_valid_r <= 1'b0;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.in_take) begin
      kind_r <= in_kind;
      ts_r   <= in_timestamp_us;
    end
    if (cmd.evt) diff_r <= diff_sat;
    if (cmd.rate_cap) rate_r <= (quo[DIV_W-1:32] != '0) ? 32'hFFFF_FFFF : quo[31:0];
    if (cmd.alpha_cap) begin
      alpha_r <= (quo >= DIV_W'(ALPHA_TABLE_ENTRIES)) ? 17'h1_0000
                                                      : {1'b0, ALPHA_TAB[quo[AIDX_W-1:0]]};
    end
    if (cmd.alpha_cap) up_r <= (rate_r >= avg_r);
    if (cmd.mul) prod_r <= alpha_r * absd;
    if (cmd.out_load) begin
      o_int_r    <= diff_r;
      o_frames_r <= 9'(count_r);
      if (total_r == 40'd0) begin
        o_rate_r   <= '0;
        o_smooth_r <= '0;
        o_rv_r     <= 1'b0;
      end else begin
        o_rate_r   <= rate_r;
        o_smooth_r <= avg_r;
        o_rv_r     <= 1'b1;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_interval_us      = o_int_r;
  assign out_window_rate      = o_rate_r;
  assign out_smoothed_rate    = o_smooth_r;
  assign out_frames_in_window = o_frames_r;
  assign out_rate_valid       = o_rv_r;

endmodule

// ===== rtl/frame_rate_window_meter.sv =====
// frame_rate_window_meter: top level, joins the sequencer and the datapath
// depends on fwm_pkg, fwm_ctrl, fwm_dp

// usage
// - input channel (in_valid/in_ready) takes one word per event: in_kind is frame,
//   pause, resume or start, in_timestamp_us a free running microsecond time
// - a frame that is not paused yields one result word on the out_ channel:
//   interval in microseconds, window rate and smoothed rate in Q16.16, window fill and rate_valid
// - start, pause, resume and paused frames give no result
// - cfg_ channel writes the window length; cfg_ready is always high, write only
//   while the block is idle
// - one event at a time: in_ready is high only when the sequencer is idle
// - a non-frame event passes the event state and returns to idle
// - a frame passes the event state, a drop when the queue is full, the push, and
//   the read and check states, repeated per dropped interval; unless the window
//   total is zero it then takes two passes of the shared bit-serial divider (rate,
//   then alpha index), then multiply, update and the output load, which waits
//   while a stalled receiver still holds the previous result
// - the result sits in an output register, so the next event is taken while
//   the previous result waits; a stalled receiver holds the sequencer only when
//   a second result is ready to go out
// - synchronous active low reset clears the time base, queue pointers and the
//   average; the queue memory itself is not cleared

module frame_rate_window_meter import fwm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_sample_window_us,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [47:0] in_timestamp_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_interval_us,
  output logic [31:0] out_window_rate,
  output logic [31:0] out_smoothed_rate,
  output logic [8:0]  out_frames_in_window,
  output logic        out_rate_valid
);

  fwm_cmd_t  cmd;
  fwm_stat_t st;

  // config word is taken every cycle it is offered
  assign cfg_ready = 1'b1;

  fwm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  fwm_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .st                   (st),
    .cfg_valid            (cfg_valid),
    .cfg_sample_window_us (cfg_sample_window_us),
    .in_kind              (in_kind),
    .in_timestamp_us      (in_timestamp_us),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_interval_us      (out_interval_us),
    .out_window_rate      (out_window_rate),
    .out_smoothed_rate    (out_smoothed_rate),
    .out_frames_in_window (out_frames_in_window),
    .out_rate_valid       (out_rate_valid)
  );

endmodule

// ===== rtl/fwm_checker.sv =====
// fwm_checker: port level assertions for the frame rate window meter
// depends on the top level ports only, bound to frame_rate_window_meter

module fwm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_window_rate,
  input logic [31:0] out_smoothed_rate,
  input logic [8:0]  out_frames_in_window,
  input logic        out_rate_valid
);

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word right after reset");

  // a pending result is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word lost while stalled");

  // an invalid rate comes with zero rates
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rate_valid |-> out_window_rate == 32'd0 && out_smoothed_rate == 32'd0)
    else $error("rate fields nonzero with rate_valid low");

  // a valid rate needs at least one interval in the window
  a_valid_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rate_valid |-> out_frames_in_window != 9'd0)
    else $error("valid rate with empty window");

  // an accepted event is not followed by another acceptance next cycle
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("event taken while previous one in flight");

endmodule

bind frame_rate_window_meter fwm_checker u_fwm_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_window_rate      (out_window_rate),
  .out_smoothed_rate    (out_smoothed_rate),
  .out_frames_in_window (out_frames_in_window),
  .out_rate_valid       (out_rate_valid)
);
